[rtl/svs_pkg.sv]
`default_nettype none

package svs_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_GRID_DEF   = 64;
   localparam int MAX_RADIUS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 8;

   // Bitmap geometry: one 64-bit word per (y, z) row, 64 x 64 rows.
   localparam int WORD_W  = 64;
   localparam int ROW_W   = 6;
   localparam int ADDR_W  = 2 * ROW_W;
   localparam int DEPTH   = 1 << ADDR_W;

   // Width of a window corner or centre after rounding, for any fraction width.
   localparam int BASE_W  = 18;

   // Configuration port.
   localparam int CFG_AW  = 5;
   localparam int CFG_DW  = 32;

   // Register indexes.
   localparam logic [2:0] REG_GRID_SIZE_X     = 3'd0;
   localparam logic [2:0] REG_GRID_SIZE_Y     = 3'd1;
   localparam logic [2:0] REG_GRID_SIZE_Z     = 3'd2;
   localparam logic [2:0] REG_SPHERE_RADIUS   = 3'd3;
   localparam logic [2:0] REG_RADIUS_SQ_LIMIT = 3'd4;
   localparam logic [2:0] REG_GRID_PADDING    = 3'd5;

   // Request kinds.
   typedef enum logic [1:0] {
      KIND_STAMP = 2'd0,
      KIND_READ  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_NOP   = 2'd3
   } kind_type;

   // Configuration register contents.
   typedef struct packed {
      logic [6:0]  grid_size_x;
      logic [6:0]  grid_size_y;
      logic [6:0]  grid_size_z;
      logic [4:0]  sphere_radius;
      logic [10:0] radius_sq_limit;
      logic [6:0]  grid_padding;
   } cfg_type;

   // Window of one axis: clipped range [start, stop) and the sphere centre.
   typedef struct packed {
      logic                     valid;
      logic [6:0]               start;
      logic [6:0]               stop;
      logic signed [BASE_W-1:0] centre;
   } axis_win_type;

   // Square of a small signed offset.
   function automatic logic [10:0] square6(input logic signed [5:0] v);
      logic [5:0] m;
      m = v[5] ? 6'(-v) : 6'(v);
      return 11'({5'b0, m} * {5'b0, m});
   endfunction

endpackage

`default_nettype wire

[rtl/sphere_voxel_stamper.sv]
`default_nettype none

// Channel    Dir  Handshake                   Payload
// req_       in   req_tvalid / req_tready     tdata: centre_x, centre_y, centre_z, word_index;
//                                             tuser: kind
// rsp_       out  rsp_tvalid / rsp_tready     tdata: word_bits, any_stamped
// csr_       in   APB, pready always high     registers at byte address 4 * index
//
// A stamp computes its clipped window and then walks the bitmap rows in it, up to
// (2 * radius)^2 rows (1024 at radius 16), and skips the walk when the window is empty: the row
// walk does one read-modify-write of the bitmap memory per cycle. A clear zeroes the
// whole bitmap before it answers.
// After reset a clearing pass zeroes the bitmap with req_tready low.
// One request is worked on at a time; the next is taken while a result waits in the
// output register, and a stalled result holds the next one back at its end.

module sphere_voxel_stamper
   import svs_pkg::*;
#(
   parameter int MAX_GRID   = MAX_GRID_DEF,
   parameter int MAX_RADIUS = MAX_RADIUS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // centre_x [15:0], centre_y [31:16], centre_z [47:32], word_index [59:48], zeros
   input  wire logic [63:0]       req_tdata,
   // kind [1:0]
   input  wire logic [1:0]        req_tuser,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // word_bits [63:0], any_stamped [64], zeros
   output logic [71:0]            rsp_tdata,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CFG_AW-1:0] csr_paddr,
   input  wire logic [CFG_DW-1:0] csr_pwdata,
   output logic      [CFG_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_SETUP = 7'b0000100,
      ST_LANES = 7'b0001000,
      ST_WALK  = 7'b0010000,
      ST_DRAIN = 7'b0100000,
      ST_RESP  = 7'b1000000
   } state_type;

   cfg_type      cfg;
   axis_win_type win_x, win_y, win_z;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic               clr_resp_ff, clr_resp_in;
   logic               found_ff, found_in;
   logic               is_read_ff, is_read_in;
   logic [ROW_W-1:0]   y_ff, y_in, z_ff, z_in;
   logic [WORD_W-1:0]  xin_ff;
   logic [10:0]        xsq_ff [WORD_W];
   logic               wvalid_ff, wvalid_in;
   logic [ADDR_W-1:0]  waddr_ff, waddr_in;
   logic [WORD_W-1:0]  wmask_ff, wmask_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_word_ff;
   logic               rsp_flag_ff;

   logic [6:0]         dim_x, dim_y, dim_z;
   logic [4:0]         radius;
   logic signed [7:0]  shift;
   logic               accept;
   logic               start_stamp;
   kind_type           kind;
   logic               empty;
   logic               last_y, last_z;
   logic               rsp_load;
   logic [WORD_W-1:0]  lane_in;
   logic [10:0]        lane_sq [WORD_W];
   logic [WORD_W-1:0]  row_mask;
   logic [11:0]        part;

   logic               ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]  ram_wr_addr, ram_rd_addr;
   logic [WORD_W-1:0]  ram_wr_data, ram_rd_data;

   svs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Saturated sizes and radius, and the padding shift of the corner.
   always_comb begin
      dim_x  = (int'(cfg.grid_size_x) > MAX_GRID) ? 7'(MAX_GRID) : cfg.grid_size_x;
      dim_y  = (int'(cfg.grid_size_y) > MAX_GRID) ? 7'(MAX_GRID) : cfg.grid_size_y;
      dim_z  = (int'(cfg.grid_size_z) > MAX_GRID) ? 7'(MAX_GRID) : cfg.grid_size_z;
      radius = (int'(cfg.sphere_radius) > MAX_RADIUS) ? 5'(MAX_RADIUS) : cfg.sphere_radius;
      shift  = $signed({1'b0, cfg.grid_padding}) - $signed({3'b000, radius});
   end

   assign req_tready  = (state_ff == ST_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign kind        = kind_type'(req_tuser);
   assign start_stamp = accept && (kind == KIND_STAMP);

   svs_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
      .clock (clock), .reset (reset), .start (start_stamp),
      .centre_pos ($signed(req_tdata[15:0])), .shift (shift),
      .dim (dim_x), .radius (radius), .win (win_x)
   );

   svs_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
      .clock (clock), .reset (reset), .start (start_stamp),
      .centre_pos ($signed(req_tdata[31:16])), .shift (shift),
      .dim (dim_y), .radius (radius), .win (win_y)
   );

   svs_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_z (
      .clock (clock), .reset (reset), .start (start_stamp),
      .centre_pos ($signed(req_tdata[47:32])), .shift (shift),
      .dim (dim_z), .radius (radius), .win (win_z)
   );

   assign empty = (win_x.start >= win_x.stop) || (win_y.start >= win_y.stop) ||
                  (win_z.start >= win_z.stop);

   // Per-column terms of the stamp: inside the x window, and squared x offset.
   always_comb begin
      logic signed [BASE_W-1:0] off;
      for (int x = 0; x < WORD_W; x++) begin
         off        = $signed(BASE_W'(x)) - win_x.centre;
         lane_sq[x] = square6(off[5:0]);
         lane_in[x] = (7'(x) >= win_x.start) && (7'(x) < win_x.stop);
      end
   end

   // Bits to set in the current row.
   always_comb begin
      logic signed [BASE_W-1:0] off_y, off_z;
      off_y = $signed(BASE_W'(y_ff)) - win_y.centre;
      off_z = $signed(BASE_W'(z_ff)) - win_z.centre;
      part  = 12'(square6(off_y[5:0])) + 12'(square6(off_z[5:0]));
      for (int x = 0; x < WORD_W; x++) begin
         row_mask[x] = xin_ff[x] &&
                       ((13'(xsq_ff[x]) + 13'(part)) <= 13'(cfg.radius_sq_limit));
      end
   end

   assign last_y   = ({1'b0, y_ff} == (win_y.stop - 7'd1));
   assign last_z   = ({1'b0, z_ff} == (win_z.stop - 7'd1));
   assign rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_tready);

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      clr_resp_in = clr_resp_ff;
      found_in    = found_ff;
      is_read_in  = is_read_ff;
      y_in        = y_ff;
      z_in        = z_ff;
      wvalid_in   = 1'b0;
      waddr_in    = {z_ff, y_ff};
      wmask_in    = row_mask;
      ram_rd_en   = 1'b0;
      ram_rd_addr = {z_ff, y_ff};
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == '1) begin
               state_in = clr_resp_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               is_read_in = 1'b0;
               case (kind)
                  KIND_STAMP: begin
                     found_in = 1'b1;
                     state_in = ST_SETUP;
                  end
                  KIND_READ: begin
                     is_read_in  = 1'b1;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = req_tdata[59:48];
                     state_in    = ST_RESP;
                  end
                  KIND_CLEAR: begin
                     found_in    = 1'b0;
                     clr_cnt_in  = '0;
                     clr_resp_in = 1'b1;
                     state_in    = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_SETUP: begin
            if (win_x.valid) begin
               state_in = ST_LANES;
            end
         end
         ST_LANES: begin
            y_in     = win_y.start[ROW_W-1:0];
            z_in     = win_z.start[ROW_W-1:0];
            state_in = empty ? ST_RESP : ST_WALK;
         end
         ST_WALK: begin
            ram_rd_en = 1'b1;
            wvalid_in = 1'b1;
            if (last_y) begin
               y_in = win_y.start[ROW_W-1:0];
               if (last_z) begin
                  state_in = ST_DRAIN;
               end else begin
                  z_in = z_ff + 1'b1;
               end
            end else begin
               y_in = y_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Write port: the clearing pass, or the second half of a row read-modify-write.
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = wvalid_ff;
         ram_wr_addr = waddr_ff;
         ram_wr_data = ram_rd_data | wmask_ff;
      end
   end

   svs_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_mask_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         clr_resp_ff  <= 1'b0;
         found_ff     <= 1'b0;
         wvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_resp_ff  <= clr_resp_in;
         found_ff     <= found_in;
         wvalid_ff    <= wvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      is_read_ff <= is_read_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      waddr_ff   <= waddr_in;
      wmask_ff   <= wmask_in;
      if (state_ff == ST_LANES) begin
         xin_ff <= lane_in;
         for (int x = 0; x < WORD_W; x++) begin
            xsq_ff[x] <= lane_sq[x];
         end
      end
      if (rsp_load) begin
         rsp_word_ff <= is_read_ff ? ram_rd_data : '0;
         rsp_flag_ff <= found_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_flag_ff, rsp_word_ff};

endmodule

`default_nettype wire

[rtl/svs_ram.sv]
`default_nettype none

module svs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; the read data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/svs_csr.sv]
`default_nettype none

module svs_csr
   import svs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CFG_AW-1:0] csr_paddr,
   input  wire logic [CFG_DW-1:0] csr_pwdata,
   output logic      [CFG_DW-1:0] csr_prdata,
   output logic                   csr_pready,
   output cfg_type                cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic [2:0]  index;
   logic        write;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[CFG_AW-1:2];
   assign write      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register writes, each masked to the register's width.
   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (index)
            REG_GRID_SIZE_X:     cfg_in.grid_size_x     = csr_pwdata[6:0];
            REG_GRID_SIZE_Y:     cfg_in.grid_size_y     = csr_pwdata[6:0];
            REG_GRID_SIZE_Z:     cfg_in.grid_size_z     = csr_pwdata[6:0];
            REG_SPHERE_RADIUS:   cfg_in.sphere_radius   = csr_pwdata[4:0];
            REG_RADIUS_SQ_LIMIT: cfg_in.radius_sq_limit = csr_pwdata[10:0];
            REG_GRID_PADDING:    cfg_in.grid_padding    = csr_pwdata[6:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_size_x     <= 7'd64;
         cfg_ff.grid_size_y     <= 7'd64;
         cfg_ff.grid_size_z     <= 7'd64;
         cfg_ff.sphere_radius   <= 5'd4;
         cfg_ff.radius_sq_limit <= 11'd16;
         cfg_ff.grid_padding    <= 7'd16;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back multiplexer.
   always_comb begin
      case (index)
         REG_GRID_SIZE_X:     csr_prdata = CFG_DW'(cfg_ff.grid_size_x);
         REG_GRID_SIZE_Y:     csr_prdata = CFG_DW'(cfg_ff.grid_size_y);
         REG_GRID_SIZE_Z:     csr_prdata = CFG_DW'(cfg_ff.grid_size_z);
         REG_SPHERE_RADIUS:   csr_prdata = CFG_DW'(cfg_ff.sphere_radius);
         REG_RADIUS_SQ_LIMIT: csr_prdata = CFG_DW'(cfg_ff.radius_sq_limit);
         REG_GRID_PADDING:    csr_prdata = CFG_DW'(cfg_ff.grid_padding);
         default:             csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/svs_axis.sv]
`default_nettype none

module svs_axis
   import svs_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [15:0] centre_pos,
   input  wire logic signed [7:0]  shift,
   input  wire logic [6:0]         dim,
   input  wire logic [4:0]         radius,
   output axis_win_type            win
);

   // Wide enough for the shifted fixed-point position and its negation.
   localparam int PW = ((FRAC_BITS + 8 > 16) ? FRAC_BITS + 8 : 16) + 2;
   localparam logic [PW-1:0] HALF = PW'((2 ** FRAC_BITS) / 2);

   logic                     v1_ff, v2_ff, v3_ff;
   logic signed [PW-1:0]     pos_ff;
   logic signed [BASE_W-1:0] corner_ff;
   logic [6:0]               start_ff, stop_ff;
   logic signed [BASE_W-1:0] centre_ff;

   logic [PW-1:0]            mag;
   logic [PW-1:0]            rnd;
   logic signed [PW-1:0]     corner_in;
   logic signed [BASE_W-1:0] dim_s;
   logic signed [BASE_W-1:0] span_end;
   logic [6:0]               start_in, stop_in;

   // Rounding of the position half away from zero.
   always_comb begin
      mag       = pos_ff[PW-1] ? PW'(-pos_ff) : PW'(pos_ff);
      rnd       = (mag + HALF) >> FRAC_BITS;
      corner_in = pos_ff[PW-1] ? -$signed(rnd) : $signed(rnd);
   end

   // Clipping of the window [corner, corner + 2r) to [0, dim).
   always_comb begin
      dim_s    = $signed(BASE_W'(dim));
      span_end = corner_ff + $signed(BASE_W'({radius, 1'b0}));
      if (corner_ff < 0) begin
         start_in = 7'd0;
      end else if (corner_ff >= dim_s) begin
         start_in = dim;
      end else begin
         start_in = corner_ff[6:0];
      end
      if (span_end <= 0) begin
         stop_in = 7'd0;
      end else if (span_end < dim_s) begin
         stop_in = span_end[6:0];
      end else begin
         stop_in = dim;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Three stages: shifted position, rounded corner, clipped window and centre.
   always_ff @(posedge clock) begin
      if (start) begin
         pos_ff <= PW'(centre_pos) + (PW'(shift) <<< FRAC_BITS);
      end
      if (v1_ff) begin
         corner_ff <= BASE_W'(corner_in);
      end
      if (v2_ff) begin
         start_ff  <= start_in;
         stop_ff   <= stop_in;
         centre_ff <= corner_ff + $signed(BASE_W'(radius));
      end
   end

   assign win.valid  = v3_ff;
   assign win.start  = start_ff;
   assign win.stop   = stop_ff;
   assign win.centre = centre_ff;

endmodule

`default_nettype wire

[sim/tb_sphere_voxel_stamper.sv]
`timescale 1ns / 100ps

module tb_sphere_voxel_stamper;
   import svs_pkg::*;

   localparam int     CYCLE_LIMIT = 3000000;
   localparam int     ROWS        = 64;
   localparam longint UNIT        = longint'(1) << FRAC_BITS_DEF;

   // One expected response: the row word and the sticky stamp flag.
   typedef struct {
      logic [63:0] word_bits;
      logic        any_stamped;
   } row_reply_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   // centre_x [15:0], centre_y [31:16], centre_z [47:32], word_index [59:48], zeros
   logic [63:0]       req_tdata   = '0;
   // kind [1:0]
   logic [1:0]        req_tuser   = KIND_NOP;
   logic              req_tvalid  = 1'b0;
   wire               req_tready;
   // word_bits [63:0], any_stamped [64], zeros
   wire  [71:0]       rsp_tdata;
   wire               rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CFG_AW-1:0] csr_paddr   = '0;
   logic [CFG_DW-1:0] csr_pwdata  = '0;
   wire  [CFG_DW-1:0] csr_prdata;
   wire               csr_pready;

   // Predicted bitmap, flag and register copies.
   logic [63:0] voxel_rows [DEPTH];
   logic        stamped_flag = 1'b0;
   logic [6:0]  size_x   = 7'd64;
   logic [6:0]  size_y   = 7'd64;
   logic [6:0]  size_z   = 7'd64;
   logic [4:0]  radius   = 5'd4;
   logic [10:0] sq_limit = 11'd16;
   logic [6:0]  padding  = 7'd16;

   row_reply_type pending_replies[$];

   int error_count  = 0;
   int cycle_count  = 0;
   int hold_left    = 0;
   int reply_count  = 0;
   int stamp_count  = 0;
   int read_count   = 0;
   int clear_count  = 0;
   int nop_count    = 0;
   int config_count = 0;
   int setting_count = 0;
   bit req_gaps     = 1'b0;
   bit rsp_gaps     = 1'b0;
   bit offering     = 1'b0;

   // Corner and span of the latest stamp, used to aim reads at touched rows.
   int last_dy   = 28;
   int last_dz   = 28;
   int last_span = 8;

   sphere_voxel_stamper DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Response acceptance: random stalls, plus a long hold counted down here.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_gaps) begin
         rsp_tready <= ($urandom_range(0, 99) >= 16);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      if (error_count <= 40)
         $display("MISMATCH at cycle %0d, %s: got %h, want %h", cycle_count, what, got, want);
   endtask

   // Compare an accepted response with the oldest expectation.
   task automatic check_reply(logic [71:0] data);
      row_reply_type want;
      if (pending_replies.size() == 0) begin
         report_mismatch("response with no request pending", data[63:0], '0);
         return;
      end
      want = pending_replies.pop_front();
      reply_count++;
      if (data[63:0] !== want.word_bits)
         report_mismatch("word_bits", data[63:0], want.word_bits);
      if (data[64] !== want.any_stamped)
         report_mismatch("any_stamped", 64'(data[64]), 64'(want.any_stamped));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_reply(rsp_tdata);
   end

   // ---------------------------------------------------------------------
   // Bitmap predictor
   // ---------------------------------------------------------------------

   function automatic void clear_bitmap();
      foreach (voxel_rows[i])
         voxel_rows[i] = '0;
      stamped_flag = 1'b0;
   endfunction

   // Window corner on one axis, rounded half away from zero.
   function automatic longint round_corner(logic [15:0] field, longint shift);
      longint p;
      p = longint'($signed(field)) + shift * UNIT;
      if (p >= 0)
         return (p + UNIT / 2) / UNIT;
      return -((-p + UNIT / 2) / UNIT);
   endfunction

   function automatic longint clip_size(logic [6:0] s);
      return (s > ROWS) ? ROWS : longint'(s);
   endfunction

   function automatic longint saturated_radius();
      return (radius > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : longint'(radius);
   endfunction

   // Set every voxel of the clipped cube window that lies within the limit.
   function automatic void stamp_sphere(logic [15:0] cx, logic [15:0] cy, logic [15:0] cz);
      longint r, shift, dx, dy, dz, sx, ex, sy, ey, sz, ez;
      longint x, y, z, ox, oy, oz, part;
      r = saturated_radius();
      shift = longint'(padding) - r;
      dx = round_corner(cx, shift);
      dy = round_corner(cy, shift);
      dz = round_corner(cz, shift);
      sx = (dx < 0) ? 0 : dx;
      sy = (dy < 0) ? 0 : dy;
      sz = (dz < 0) ? 0 : dz;
      ex = (dx + 2 * r < clip_size(size_x)) ? dx + 2 * r : clip_size(size_x);
      ey = (dy + 2 * r < clip_size(size_y)) ? dy + 2 * r : clip_size(size_y);
      ez = (dz + 2 * r < clip_size(size_z)) ? dz + 2 * r : clip_size(size_z);
      stamped_flag = 1'b1;
      last_dy = int'(dy);
      last_dz = int'(dz);
      last_span = int'(2 * r);
      for (z = sz; z < ez; z++) begin
         oz = z - dz - r;
         for (y = sy; y < ey; y++) begin
            oy = y - dy - r;
            part = oz * oz + oy * oy;
            for (x = sx; x < ex; x++) begin
               ox = x - dx - r;
               if (part + ox * ox <= longint'(sq_limit))
                  voxel_rows[int'((z * ROWS + y) & (DEPTH - 1))][int'(x & 63)] = 1'b1;
            end
         end
      end
   endfunction

   // Apply one accepted request and queue the response it must produce.
   function automatic void predict_reply(kind_type kind, logic [63:0] data);
      row_reply_type reply;
      reply.word_bits = '0;
      case (kind)
         KIND_STAMP: begin
            stamp_sphere(data[15:0], data[31:16], data[47:32]);
            stamp_count++;
         end
         KIND_READ: begin
            reply.word_bits = voxel_rows[data[59:48]];
            read_count++;
         end
         KIND_CLEAR: begin
            clear_bitmap();
            clear_count++;
         end
         default: begin
            nop_count++;
         end
      endcase
      reply.any_stamped = stamped_flag;
      pending_replies.push_back(reply);
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   task automatic lower_request();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   // Offer one request and wait until it is taken.
   task automatic send_request(kind_type kind, logic [15:0] cx, logic [15:0] cy,
                               logic [15:0] cz, logic [11:0] index);
      if (req_gaps && $urandom_range(0, 99) < 16) begin
         lower_request();
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      offering = 1'b1;
      req_tuser <= kind;
      req_tdata <= {4'b0, index, cz, cy, cx};
      do @(posedge clock); while (!req_tready);
      predict_reply(kind, {4'b0, index, cz, cy, cx});
   endtask

   // Stop offering and wait until every expected response has arrived.
   task automatic wait_idle();
      lower_request();
      while (pending_replies.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Register access
   // ---------------------------------------------------------------------

   function automatic logic [31:0] field_mask(logic [2:0] index);
      case (index)
         REG_SPHERE_RADIUS:   return 32'h1F;
         REG_RADIUS_SQ_LIMIT: return 32'h7FF;
         default:             return 32'h7F;
      endcase
   endfunction

   function automatic logic [31:0] register_value(logic [2:0] index);
      case (index)
         REG_GRID_SIZE_X:     return 32'(size_x);
         REG_GRID_SIZE_Y:     return 32'(size_y);
         REG_GRID_SIZE_Z:     return 32'(size_z);
         REG_SPHERE_RADIUS:   return 32'(radius);
         REG_RADIUS_SQ_LIMIT: return 32'(sq_limit);
         default:             return 32'(padding);
      endcase
   endfunction

   // Write one register; bits above the field carry random noise.
   task automatic csr_write(logic [2:0] index, logic [31:0] value);
      logic [31:0] word;
      word = $urandom;
      word = (word & ~field_mask(index)) | (value & field_mask(index));
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_GRID_SIZE_X:     size_x   = word[6:0];
         REG_GRID_SIZE_Y:     size_y   = word[6:0];
         REG_GRID_SIZE_Z:     size_z   = word[6:0];
         REG_SPHERE_RADIUS:   radius   = word[4:0];
         REG_RADIUS_SQ_LIMIT: sq_limit = word[10:0];
         default:             padding  = word[6:0];
      endcase
      config_count++;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check(logic [2:0] index);
      logic [31:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {index, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      if (got !== register_value(index))
         report_mismatch($sformatf("register %0d readback", index), 64'(got),
                         64'(register_value(index)));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_back_registers();
      csr_read_check(REG_GRID_SIZE_X);
      csr_read_check(REG_GRID_SIZE_Y);
      csr_read_check(REG_GRID_SIZE_Z);
      csr_read_check(REG_SPHERE_RADIUS);
      csr_read_check(REG_RADIUS_SQ_LIMIT);
      csr_read_check(REG_GRID_PADDING);
   endtask

   // Load a full register setting once the block has gone idle.
   task automatic program_registers(int sx, int sy, int sz, int r, int lim, int pad);
      wait_idle();
      csr_write(REG_GRID_SIZE_X, sx);
      csr_write(REG_GRID_SIZE_Y, sy);
      csr_write(REG_GRID_SIZE_Z, sz);
      csr_write(REG_SPHERE_RADIUS, r);
      csr_write(REG_RADIUS_SQ_LIMIT, lim);
      csr_write(REG_GRID_PADDING, pad);
      read_back_registers();
      setting_count++;
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic logic [15:0] voxels(int v);
      return 16'(v * 256);
   endfunction

   function automatic logic [5:0] clamp_row(int v);
      if (v < 0)
         return 6'd0;
      if (v > ROWS - 1)
         return 6'(ROWS - 1);
      return 6'(v);
   endfunction

   // Centre that mostly lands the window on or near the grid.
   function automatic logic [15:0] random_centre(longint dim);
      int r, lo, hi, v, frac;
      if ($urandom_range(0, 99) < 20)
         return 16'($urandom);
      r = int'(saturated_radius());
      lo = -int'(padding) - r - 1;
      hi = int'(dim) - int'(padding) + r;
      v = lo + int'($urandom_range(0, hi - lo));
      if (v < -128)
         v = -128;
      if (v > 127)
         v = 127;
      frac = ($urandom_range(0, 3) == 0) ? 128 : int'($urandom_range(0, 255));
      return 16'(v * 256 + frac);
   endfunction

   // Stamp, then read the corner row and the centre row of its window.
   task automatic stamp_and_probe(logic [15:0] cx, logic [15:0] cy, logic [15:0] cz);
      send_request(KIND_STAMP, cx, cy, cz, 12'($urandom));
      send_request(KIND_READ, 16'($urandom), 16'($urandom), 16'($urandom),
                   {clamp_row(last_dz), clamp_row(last_dy)});
      send_request(KIND_READ, 16'($urandom), 16'($urandom), 16'($urandom),
                   {clamp_row(last_dz + last_span / 2), clamp_row(last_dy + last_span / 2)});
   endtask

   task automatic random_request();
      int          roll;
      logic [11:0] index;
      logic [15:0] cx, cy, cz;
      cx = random_centre(clip_size(size_x));
      cy = random_centre(clip_size(size_y));
      cz = random_centre(clip_size(size_z));
      index = 12'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 48) begin
         send_request(KIND_STAMP, cx, cy, cz, index);
      end else if (roll < 90) begin
         if ($urandom_range(0, 99) < 70)
            index = {clamp_row(last_dz + int'($urandom_range(0, last_span))),
                     clamp_row(last_dy + int'($urandom_range(0, last_span)))};
         send_request(KIND_READ, cx, cy, cz, index);
      end else if (roll < 92) begin
         send_request(KIND_CLEAR, cx, cy, cz, index);
      end else begin
         send_request(KIND_NOP, cx, cy, cz, index);
      end
   endtask

   function automatic int pick_size();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         return $urandom_range(0, 7);
      if (roll < 20)
         return $urandom_range(65, 127);
      return $urandom_range(8, 64);
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Empty bitmap, clear flag and register defaults after reset.
   task automatic test_reset_defaults();
      send_request(KIND_NOP, 16'h0, 16'h0, 16'h0, 12'h0);
      send_request(KIND_READ, 16'h0, 16'h0, 16'h0, 12'h000);
      send_request(KIND_READ, 16'h0, 16'h0, 16'h0, 12'hFFF);
      wait_idle();
      read_back_registers();
   endtask

   // Hand-picked requests at the default setting.
   task automatic test_directed_requests();
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      // Sphere well inside the grid, centre row and edge rows.
      send_request(KIND_STAMP, voxels(16), voxels(16), voxels(16), 12'h0);
      send_request(KIND_READ, 16'h0, 16'h0, 16'h0, {6'd32, 6'd32});
      send_request(KIND_READ, 16'h0, 16'h0, 16'h0, {6'd32, 6'd28});
      send_request(KIND_READ, 16'h0, 16'h0, 16'h0, {6'd36, 6'd32});
      // Rounding of exact halves: up when positive, away from zero when negative,
      // and a value just short of minus one half that rounds to zero.
      send_request(KIND_STAMP, 16'h0080, voxels(20), voxels(8), 12'h0);
      send_request(KIND_STAMP, 16'hF380, 16'hF381, 16'hF300, 12'h0);
      send_request(KIND_READ, 16'h0, 16'h0, 16'h0, {6'd3, 6'd4});
      // Extreme centres: the window lies wholly outside, yet the flag is set.
      send_request(KIND_STAMP, 16'h7FFF, 16'h7FFF, 16'h7FFF, 12'hFFF);
      send_request(KIND_STAMP, 16'h8000, 16'h8000, 16'h8000, 12'h000);
      // Window beyond the high y edge, so nothing is stamped.
      send_request(KIND_STAMP, voxels(-10), voxels(60), voxels(30), 12'h0);
      send_request(KIND_READ, 16'h0, 16'h0, 16'h0, {6'd42, 6'd63});
      send_request(KIND_READ, 16'h0, 16'h0, 16'h0, 12'h000);
      send_request(KIND_READ, 16'h0, 16'h0, 16'h0, 12'hFFF);
      // Unused kind changes nothing; a clear empties the bitmap and drops the flag.
      send_request(KIND_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF);
      send_request(KIND_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF);
      send_request(KIND_READ, 16'h0, 16'h0, 16'h0, {6'd32, 6'd32});
      send_request(KIND_NOP, 16'h0, 16'h0, 16'h0, 12'h0);
      send_request(KIND_STAMP, voxels(16), voxels(16), voxels(16), 12'h0);
      send_request(KIND_READ, 16'h0, 16'h0, 16'h0, {6'd32, 6'd32});
   endtask

   // Register extremes: empty, saturated, single-voxel and zero-radius grids.
   task automatic test_register_extremes();
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      program_registers(0, 0, 0, 4, 16, 16);
      send_request(KIND_CLEAR, 16'h0, 16'h0, 16'h0, 12'h0);
      stamp_and_probe(voxels(4), voxels(4), voxels(4));

      program_registers(127, 127, 127, 31, 2047, 127);
      stamp_and_probe(16'h8000, 16'h8000, 16'h8000);
      stamp_and_probe(voxels(-100), voxels(-95), voxels(-110));

      program_registers(1, 1, 1, 1, 0, 0);
      send_request(KIND_CLEAR, 16'h0, 16'h0, 16'h0, 12'h0);
      stamp_and_probe(voxels(0), voxels(0), voxels(0));
      stamp_and_probe(voxels(1), voxels(0), voxels(0));

      program_registers(64, 64, 64, 0, 0, 0);
      stamp_and_probe(voxels(10), voxels(10), voxels(10));

      program_registers(64, 7, 33, 16, 0, 64);
      send_request(KIND_CLEAR, 16'h0, 16'h0, 16'h0, 12'h0);
      stamp_and_probe(voxels(-40), voxels(-40), voxels(-40));
      stamp_and_probe(voxels(-40), voxels(-62), voxels(-40));
      send_request(KIND_READ, 16'h0, 16'h0, 16'h0, {6'd24, 6'd2});

      program_registers(64, 64, 64, 4, 16, 16);
      send_request(KIND_CLEAR, 16'h0, 16'h0, 16'h0, 12'h0);
   endtask

   // Long response hold while requests keep coming, then a full drain.
   task automatic test_output_backpressure();
      int i;
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      send_request(KIND_STAMP, voxels(20), voxels(20), voxels(20), 12'h0);
      hold_left = 300;
      for (i = 0; i < 12; i++)
         send_request((i % 4 == 3) ? KIND_NOP : KIND_READ, 16'($urandom), 16'($urandom),
                      16'($urandom), {6'(32 + i % 8), 6'(32 + i / 2)});
      wait_idle();
      rsp_gaps = 1'b1;
      stamp_and_probe(voxels(30), voxels(10), voxels(40));
   endtask

   // Random settings, each followed by a burst of random requests.
   task automatic test_random_traffic();
      int phase, i, roll, r, sr, lim, pad;
      for (phase = 0; phase < 10; phase++) begin
         roll = $urandom_range(0, 99);
         if (roll < 5)
            r = 0;
         else if (roll < 70)
            r = $urandom_range(1, 6);
         else if (roll < 88)
            r = $urandom_range(7, 16);
         else
            r = $urandom_range(17, 31);
         sr = (r > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : r;
         if ($urandom_range(0, 99) < 15) begin
            lim = $urandom_range(0, 2047);
         end else begin
            lim = sr * sr + int'($urandom_range(0, 2 * sr)) - sr;
            if (lim < 0)
               lim = 0;
         end
         pad = ($urandom_range(0, 99) < 15) ? $urandom_range(25, 127) : $urandom_range(0, 24);
         program_registers(pick_size(), pick_size(), pick_size(), r, lim, pad);
         // The first phase runs with no idling on either side.
         req_gaps = (phase != 0);
         rsp_gaps = (phase != 0);
         if ($urandom_range(0, 1) == 1)
            send_request(KIND_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                         12'($urandom));
         for (i = 0; i < 50; i++)
            random_request();
      end
   endtask

   initial begin
      clear_bitmap();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_directed_requests();
      test_register_extremes();
      test_output_backpressure();
      test_random_traffic();

      wait_idle();
      repeat (64) @(posedge clock);

      $display("Checked %0d responses: %0d stamps, %0d reads, %0d clears, %0d no-ops.",
               reply_count, stamp_count, read_count, clear_count, nop_count);
      $display("%0d register writes over %0d settings, %0d mismatches.",
               config_count, setting_count, error_count);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
